FILE: src/twm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transition wipe mask generator.
// No dependencies; used by every module of the block except twm_div.
package twm_pkg;

   localparam int DUR_W      = 16;
   localparam int EXT_W      = 13;
   localparam int GRAY_W     = 8;
   localparam int MASK_W     = 8;
   localparam int MODE_W     = 3;
   localparam int DIR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ID_W       = 12;
   localparam int OFS_W      = 6;
   localparam int MOD_W      = 5;
   localparam int DEN_W      = 14;
   localparam int EX_W       = 29;
   localparam int DVDA_W     = 30;
   localparam int DVDB_W     = 24;
   localparam int QUOA_W     = 16;
   localparam int QUOB_W     = 8;
   localparam int PROD_W     = 24;

   localparam logic [MASK_W-1:0] MASK_SHOW = 8'd255;
   localparam logic [MASK_W-1:0] MASK_HIDE = 8'd0;

   typedef enum logic [MODE_W-1:0] {
      MODE_BLINDS    = 3'd0,
      MODE_CURTAIN   = 3'd1,
      MODE_ROLL      = 3'd2,
      MODE_MASK_HARD = 3'd3,
      MODE_MASK_SOFT = 3'd4
   } mode_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_LEFT   = 2'd0,
      DIR_RIGHT  = 2'd1,
      DIR_TOP    = 2'd2,
      DIR_BOTTOM = 2'd3
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE      = 3'd0,
      REG_DIRECTION = 3'd1,
      REG_DURATION  = 3'd2,
      REG_ELAPSED   = 3'd3,
      REG_WIDTH     = 3'd4,
      REG_HEIGHT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      mode_type           mode;
      logic               far;
      logic               vert;
      logic [DUR_W-1:0]   d;
      logic [DUR_W-1:0]   e;
      logic [EXT_W-1:0]   x;
      logic [DUR_W-1:0]   step;
      logic [DEN_W-1:0]   den;
      logic [DUR_W-1:0]   tt;
      logic [EX_W-1:0]    ex;
   } cfg_type;

   typedef struct packed {
      logic               in_frame;
      logic [OFS_W-1:0]   o;
      logic [MOD_W-1:0]   m;
      logic [EXT_W-1:0]   p;
      logic [DUR_W-1:0]   t;
      logic [DVDB_W-1:0]  numer;
   } side_type;

   typedef struct packed {
      logic               need;
      logic [MASK_W-1:0]  vpre;
      logic [OFS_W-1:0]   o;
   } mid_type;

endpackage

FILE: src/twm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. Standalone; no package use.
module twm_div #(
   parameter int DVD_W = 30,
   parameter int DVS_W = 16,
   parameter int QUO_W = 16,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DVD_W-1:0] in_dividend,
   input  logic [DVS_W-1:0] in_divisor,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quotient,
   output logic [TAG_W-1:0] out_tag
);

   localparam int W = (DVD_W > DVS_W + QUO_W) ? DVD_W : DVS_W + QUO_W;

   logic [QUO_W-1:0] vld_ff;
   logic [W-1:0]     rem_ff [QUO_W];
   logic [DVS_W-1:0] dvs_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [TAG_W-1:0] tag_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic             src_vld;
      logic [W-1:0]     src_rem;
      logic [DVS_W-1:0] src_dvs;
      logic [QUO_W-1:0] src_quo;
      logic [TAG_W-1:0] src_tag;
      logic [W-1:0]     shifted;
      logic             ge;
      logic [W-1:0]     rem_in;
      logic [QUO_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_rem = W'(in_dividend);
         assign src_dvs = in_divisor;
         assign src_quo = '0;
         assign src_tag = in_tag;
      end else begin : g_next
         assign src_vld = vld_ff[i-1];
         assign src_rem = rem_ff[i-1];
         assign src_dvs = dvs_ff[i-1];
         assign src_quo = quo_ff[i-1];
         assign src_tag = tag_ff[i-1];
      end

      assign shifted = W'(src_dvs) << (QUO_W - 1 - i);
      assign ge      = src_rem >= shifted;
      assign rem_in  = ge ? src_rem - shifted : src_rem;
      assign quo_in  = src_quo | (QUO_W'(ge) << (QUO_W - 1 - i));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            dvs_ff[i] <= src_dvs;
            quo_ff[i] <= quo_in;
            tag_ff[i] <= src_tag;
         end
      end
   end

   assign out_valid    = vld_ff[QUO_W-1];
   assign out_quotient = quo_ff[QUO_W-1];
   assign out_tag      = tag_ff[QUO_W-1];

endmodule

FILE: src/twm_front.sv
`timescale 1ns / 1ps
// Front stages: coordinate select, block and period split, mask threshold,
// and operand select for the first divider. Depends on twm_pkg.
module twm_front #(
   parameter int COORD_BITS    = 12,
   parameter int BLIND_PERIOD  = 16,
   parameter int CURTAIN_BLOCK = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [COORD_BITS-1:0]         pixel_x,
   input  logic [COORD_BITS-1:0]         pixel_y,
   input  logic [twm_pkg::GRAY_W-1:0]    mask_gray,
   input  twm_pkg::cfg_type              cfg,
   output logic                          out_valid,
   output logic [twm_pkg::DVDA_W-1:0]    out_dividend,
   output logic [twm_pkg::DUR_W-1:0]     out_divisor,
   output twm_pkg::side_type             out_side
);

   localparam int S_BLK   = twm_pkg::EXT_W + $clog2(CURTAIN_BLOCK);
   localparam int PBLK_W  = twm_pkg::EXT_W + S_BLK;
   localparam longint unsigned M_BLK =
      ((longint'(1) << S_BLK) + CURTAIN_BLOCK - 1) / CURTAIN_BLOCK;
   localparam int S_BP    = COORD_BITS + $clog2(BLIND_PERIOD);
   localparam int PBP_W   = COORD_BITS + S_BP;
   localparam longint unsigned M_BP =
      ((longint'(1) << S_BP) + BLIND_PERIOD - 1) / BLIND_PERIOD;
   localparam int S_255   = 32;
   localparam int P255_W  = twm_pkg::PROD_W + S_255 + 1;
   localparam longint unsigned M_255 = ((longint'(1) << S_255) + 254) / 255;
   localparam int CMP_W   = 17;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [COORD_BITS-1:0]       px_ff, py_ff;
   logic [twm_pkg::GRAY_W-1:0]  g_ff;

   logic [COORD_BITS-1:0]       c_in;
   logic                        in_frame_in;
   logic [twm_pkg::EXT_W-1:0]   p_in;
   logic [PBLK_W-1:0]           pprod_in;
   logic [PBP_W-1:0]            cprod_in;
   logic [twm_pkg::PROD_W-1:0]  dg_in;

   logic [COORD_BITS-1:0]       c2_ff;
   logic                        in2_ff;
   logic [twm_pkg::EXT_W-1:0]   p2_ff;
   logic [PBLK_W-1:0]           pprod_ff;
   logic [PBP_W-1:0]            cprod_ff;
   logic [twm_pkg::PROD_W-1:0]  dg_ff;

   logic [twm_pkg::ID_W-1:0]    id_in;
   logic [COORD_BITS-1:0]       cq_in;
   logic [P255_W-1:0]           tprod_in;

   logic [COORD_BITS-1:0]       c3_ff;
   logic                        in3_ff;
   logic [twm_pkg::EXT_W-1:0]   p3_ff;
   logic [twm_pkg::ID_W-1:0]    id3_ff;
   logic [COORD_BITS-1:0]       cq3_ff;
   logic [P255_W-1:0]           tprod_ff;

   logic [twm_pkg::EXT_W-1:0]   o_full;
   logic [COORD_BITS-1:0]       m_full;
   logic [twm_pkg::MOD_W-1:0]   m_near;
   logic [twm_pkg::MOD_W-1:0]   m_in;
   logic [twm_pkg::DUR_W-1:0]   t_in;
   logic [twm_pkg::DUR_W-1:0]   te_in;
   logic [twm_pkg::DVDB_W-1:0]  numer_in;
   logic [twm_pkg::DVDA_W-1:0]  tid_in;

   twm_pkg::side_type           side4_ff;
   logic [twm_pkg::DVDA_W-1:0]  tid4_ff;

   // stage 1 -> 2
   always_comb begin
      c_in        = cfg.vert ? py_ff : px_ff;
      in_frame_in = CMP_W'(c_in) < CMP_W'(cfg.x);
      p_in        = cfg.far ? twm_pkg::EXT_W'(CMP_W'(cfg.x) - CMP_W'(1) - CMP_W'(c_in))
                            : twm_pkg::EXT_W'(c_in);
      pprod_in    = PBLK_W'(p_in) * PBLK_W'(M_BLK);
      cprod_in    = PBP_W'(c_in) * PBP_W'(M_BP);
      dg_in       = twm_pkg::PROD_W'(cfg.d) * twm_pkg::PROD_W'(g_ff);
   end

   // stage 2 -> 3
   always_comb begin
      id_in    = twm_pkg::ID_W'(pprod_ff >> S_BLK);
      cq_in    = COORD_BITS'(cprod_ff >> S_BP);
      tprod_in = P255_W'(dg_ff) * P255_W'(M_255);
   end

   // stage 3 -> 4
   always_comb begin
      o_full   = p3_ff - twm_pkg::EXT_W'(twm_pkg::EXT_W'(id3_ff)
                                        * twm_pkg::EXT_W'(CURTAIN_BLOCK));
      m_full   = c3_ff - COORD_BITS'(cq3_ff * COORD_BITS'(BLIND_PERIOD));
      m_near   = twm_pkg::MOD_W'(m_full);
      m_in     = cfg.far ? twm_pkg::MOD_W'(BLIND_PERIOD - 1) - m_near : m_near;
      t_in     = twm_pkg::DUR_W'(tprod_ff >> S_255);
      te_in    = t_in - cfg.e;
      numer_in = (twm_pkg::DVDB_W'(te_in) << 8) - twm_pkg::DVDB_W'(te_in);
      tid_in   = twm_pkg::DVDA_W'(cfg.tt) * twm_pkg::DVDA_W'(id3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff             <= pixel_x;
         py_ff             <= pixel_y;
         g_ff              <= mask_gray;
         c2_ff             <= c_in;
         in2_ff            <= in_frame_in;
         p2_ff             <= p_in;
         pprod_ff          <= pprod_in;
         cprod_ff          <= cprod_in;
         dg_ff             <= dg_in;
         c3_ff             <= c2_ff;
         in3_ff            <= in2_ff;
         p3_ff             <= p2_ff;
         id3_ff            <= id_in;
         cq3_ff            <= cq_in;
         tprod_ff          <= tprod_in;
         side4_ff.in_frame <= in3_ff;
         side4_ff.o        <= twm_pkg::OFS_W'(o_full);
         side4_ff.m        <= m_in;
         side4_ff.p        <= p3_ff;
         side4_ff.t        <= t_in;
         side4_ff.numer    <= numer_in;
         tid4_ff           <= tid_in;
      end
   end

   always_comb begin
      case (cfg.mode)
         twm_pkg::MODE_BLINDS: begin
            out_dividend = twm_pkg::DVDA_W'(cfg.e);
            out_divisor  = cfg.step;
         end
         twm_pkg::MODE_ROLL: begin
            out_dividend = twm_pkg::DVDA_W'(cfg.ex);
            out_divisor  = cfg.d;
         end
         twm_pkg::MODE_CURTAIN: begin
            out_dividend = tid4_ff + twm_pkg::DVDA_W'(cfg.den) - twm_pkg::DVDA_W'(1);
            out_divisor  = twm_pkg::DUR_W'(cfg.den);
         end
         default: begin
            out_dividend = twm_pkg::DVDA_W'(cfg.e);
            out_divisor  = cfg.d;
         end
      endcase
   end

   assign out_valid = v4_ff;
   assign out_side  = side4_ff;

endmodule

FILE: src/transition_wipe_mask_gen.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle unless a held rsp word stalls the pipeline; the
// first divider resolves a quotient bit per stage (16 stages), the second
// divider 8 stages. req_ready drops after reset and after every csr write while
// the derived configuration settles. Reset clears the pipeline valids.
// Depends on twm_pkg, twm_front, twm_div.
module transition_wipe_mask_gen #(
   parameter int COORD_BITS    = 12,
   parameter int BLIND_PERIOD  = 16,
   parameter int CURTAIN_BLOCK = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [COORD_BITS-1:0]             req_pixel_x,
   input  logic [COORD_BITS-1:0]             req_pixel_y,
   input  logic [twm_pkg::GRAY_W-1:0]        req_mask_gray,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [twm_pkg::MASK_W-1:0]        rsp_mask_value,
   input  logic                              csr_we,
   input  logic [twm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int S_D   = twm_pkg::DUR_W + $clog2(BLIND_PERIOD);
   localparam int PD_W  = twm_pkg::DUR_W + S_D;
   localparam longint unsigned M_D =
      ((longint'(1) << S_D) + BLIND_PERIOD - 1) / BLIND_PERIOD;
   localparam int XB_W  = 14;
   localparam int S_X   = XB_W + $clog2(CURTAIN_BLOCK);
   localparam int PX_W  = XB_W + S_X;
   localparam longint unsigned M_X =
      ((longint'(1) << S_X) + CURTAIN_BLOCK - 1) / CURTAIN_BLOCK;

   twm_pkg::mode_type             mode_ff;
   logic [twm_pkg::DIR_W-1:0]     dir_ff;
   logic [twm_pkg::DUR_W-1:0]     dur_ff, elap_ff;
   logic [twm_pkg::EXT_W-1:0]     width_ff, height_ff;
   logic [1:0]                    settle_ff;

   twm_pkg::mode_type             a_mode_ff;
   logic                          a_far_ff, a_vert_ff;
   logic [twm_pkg::DUR_W-1:0]     a_d_ff, a_e_ff;
   logic [twm_pkg::EXT_W-1:0]     a_x_ff;
   logic [PD_W-1:0]               a_dq_ff;
   logic [PX_W-1:0]               a_bq_ff;

   logic [twm_pkg::DUR_W-1:0]     d_in, e_in, step_in;
   logic                          vert_in, far_in;
   logic [twm_pkg::EXT_W-1:0]     x_in;
   logic [XB_W-1:0]               xb_in;
   logic [twm_pkg::DEN_W-1:0]     bc_in, den_in;

   twm_pkg::cfg_type              cfg_ff;

   logic                          en;
   logic                          fr_valid;
   logic [twm_pkg::DVDA_W-1:0]    fr_dividend;
   logic [twm_pkg::DUR_W-1:0]     fr_divisor;
   twm_pkg::side_type             fr_side;

   logic                          a_valid;
   logic [twm_pkg::QUOA_W-1:0]    qa;
   logic [$bits(twm_pkg::side_type)-1:0] a_tag;
   twm_pkg::side_type             side_a;

   twm_pkg::mid_type              mid_in, mid_ff, mid_b;
   logic [twm_pkg::DVDB_W-1:0]    dvdb_in, dvdb_ff;
   logic [twm_pkg::DUR_W-1:0]     dvsb_in, dvsb_ff;
   logic [twm_pkg::DUR_W-1:0]     r_in;
   logic                          midv_ff;

   logic                          b_valid;
   logic [twm_pkg::QUOB_W-1:0]    qb;
   logic [$bits(twm_pkg::mid_type)-1:0] b_tag;

   logic [twm_pkg::MASK_W-1:0]    out_in, out_ff;
   logic                          outv_ff;
   logic [8:0]                    osum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= twm_pkg::MODE_BLINDS;
         dir_ff    <= twm_pkg::DIR_LEFT;
         dur_ff    <= 16'd1000;
         elap_ff   <= 16'd0;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         settle_ff <= 2'd2;
      end else begin
         if (csr_we) begin
            settle_ff <= 2'd2;
            case (twm_pkg::csr_index_type'(csr_index))
               twm_pkg::REG_MODE:      mode_ff   <= twm_pkg::mode_type'(csr_wdata[2:0]);
               twm_pkg::REG_DIRECTION: dir_ff    <= csr_wdata[1:0];
               twm_pkg::REG_DURATION:  dur_ff    <= csr_wdata;
               twm_pkg::REG_ELAPSED:   elap_ff   <= csr_wdata;
               twm_pkg::REG_WIDTH:     width_ff  <= csr_wdata[12:0];
               twm_pkg::REG_HEIGHT:    height_ff <= csr_wdata[12:0];
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // derived configuration, two register stages
   always_comb begin
      d_in    = (dur_ff == '0) ? twm_pkg::DUR_W'(1) : dur_ff;
      e_in    = (elap_ff > d_in) ? d_in : elap_ff;
      vert_in = (dir_ff == twm_pkg::DIR_TOP) || (dir_ff == twm_pkg::DIR_BOTTOM);
      far_in  = (dir_ff == twm_pkg::DIR_RIGHT) || (dir_ff == twm_pkg::DIR_BOTTOM);
      x_in    = vert_in ? height_ff : width_ff;
      xb_in   = XB_W'(x_in) + XB_W'(CURTAIN_BLOCK - 1);
      step_in = twm_pkg::DUR_W'(a_dq_ff >> S_D);
      if (step_in == '0) begin
         step_in = twm_pkg::DUR_W'(1);
      end
      bc_in   = twm_pkg::DEN_W'(a_bq_ff >> S_X);
      den_in  = bc_in << 1;
   end

   always_ff @(posedge clock) begin
      a_mode_ff   <= mode_ff;
      a_far_ff    <= far_in;
      a_vert_ff   <= vert_in;
      a_d_ff      <= d_in;
      a_e_ff      <= e_in;
      a_x_ff      <= x_in;
      a_dq_ff     <= PD_W'(d_in) * PD_W'(M_D);
      a_bq_ff     <= PX_W'(xb_in) * PX_W'(M_X);
      cfg_ff.mode <= a_mode_ff;
      cfg_ff.far  <= a_far_ff;
      cfg_ff.vert <= a_vert_ff;
      cfg_ff.d    <= a_d_ff;
      cfg_ff.e    <= a_e_ff;
      cfg_ff.x    <= a_x_ff;
      cfg_ff.step <= step_in;
      cfg_ff.den  <= den_in;
      cfg_ff.tt   <= (a_d_ff < twm_pkg::DUR_W'(den_in)) ? twm_pkg::DUR_W'(den_in) : a_d_ff;
      cfg_ff.ex   <= twm_pkg::EX_W'(a_e_ff) * twm_pkg::EX_W'(a_x_ff);
   end

   assign en        = !outv_ff || rsp_ready;
   assign req_ready = en && (settle_ff == 2'd0);

   twm_front #(
      .COORD_BITS    (COORD_BITS),
      .BLIND_PERIOD  (BLIND_PERIOD),
      .CURTAIN_BLOCK (CURTAIN_BLOCK)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid && req_ready),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .mask_gray    (req_mask_gray),
      .cfg          (cfg_ff),
      .out_valid    (fr_valid),
      .out_dividend (fr_dividend),
      .out_divisor  (fr_divisor),
      .out_side     (fr_side)
   );

   twm_div #(
      .DVD_W (twm_pkg::DVDA_W),
      .DVS_W (twm_pkg::DUR_W),
      .QUO_W (twm_pkg::QUOA_W),
      .TAG_W ($bits(twm_pkg::side_type))
   ) u_div_a (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (fr_valid),
      .in_dividend  (fr_dividend),
      .in_divisor   (fr_divisor),
      .in_tag       (fr_side),
      .out_valid    (a_valid),
      .out_quotient (qa),
      .out_tag      (a_tag)
   );

   assign side_a = twm_pkg::side_type'(a_tag);

   // decide what needs no second division
   always_comb begin
      mid_in.need = 1'b0;
      mid_in.vpre = twm_pkg::MASK_SHOW;
      mid_in.o    = side_a.o;
      dvdb_in     = side_a.numer;
      dvsb_in     = side_a.t;
      r_in        = cfg_ff.e - qa;
      case (cfg_ff.mode)
         twm_pkg::MODE_BLINDS: begin
            mid_in.vpre = (twm_pkg::DUR_W'(side_a.m) < qa) ? twm_pkg::MASK_HIDE
                                                           : twm_pkg::MASK_SHOW;
         end
         twm_pkg::MODE_ROLL: begin
            if (side_a.in_frame && (twm_pkg::DUR_W'(side_a.p) <= qa)) begin
               mid_in.vpre = twm_pkg::MASK_HIDE;
            end
         end
         twm_pkg::MODE_CURTAIN: begin
            if (side_a.in_frame && (cfg_ff.e > qa)) begin
               if ({r_in, 1'b0} > {1'b0, cfg_ff.tt}) begin
                  mid_in.vpre = twm_pkg::MASK_HIDE;
               end else begin
                  mid_in.need = 1'b1;
                  dvdb_in     = twm_pkg::DVDB_W'(r_in) * twm_pkg::DVDB_W'(2 * CURTAIN_BLOCK)
                              + twm_pkg::DVDB_W'(cfg_ff.tt) - twm_pkg::DVDB_W'(1);
                  dvsb_in     = cfg_ff.tt;
               end
            end
         end
         twm_pkg::MODE_MASK_HARD: begin
            if (cfg_ff.e > side_a.t) begin
               mid_in.vpre = twm_pkg::MASK_HIDE;
            end
         end
         twm_pkg::MODE_MASK_SOFT: begin
            if (cfg_ff.e > side_a.t) begin
               mid_in.vpre = twm_pkg::MASK_HIDE;
            end else if (side_a.t != '0) begin
               mid_in.need = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         midv_ff <= 1'b0;
      end else if (en) begin
         midv_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff  <= mid_in;
         dvdb_ff <= dvdb_in;
         dvsb_ff <= dvsb_in;
      end
   end

   twm_div #(
      .DVD_W (twm_pkg::DVDB_W),
      .DVS_W (twm_pkg::DUR_W),
      .QUO_W (twm_pkg::QUOB_W),
      .TAG_W ($bits(twm_pkg::mid_type))
   ) u_div_b (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (midv_ff),
      .in_dividend  (dvdb_ff),
      .in_divisor   (dvsb_ff),
      .in_tag       (mid_ff),
      .out_valid    (b_valid),
      .out_quotient (qb),
      .out_tag      (b_tag)
   );

   assign mid_b = twm_pkg::mid_type'(b_tag);

   always_comb begin
      osum   = 9'(mid_b.o) + 9'(qb);
      out_in = mid_b.vpre;
      if (mid_b.need) begin
         if (cfg_ff.mode == twm_pkg::MODE_CURTAIN) begin
            if (cfg_ff.far) begin
               out_in = (osum >= 9'(CURTAIN_BLOCK)) ? twm_pkg::MASK_HIDE
                                                    : twm_pkg::MASK_SHOW;
            end else begin
               out_in = (8'(mid_b.o) < qb) ? twm_pkg::MASK_HIDE : twm_pkg::MASK_SHOW;
            end
         end else begin
            out_in = qb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outv_ff <= 1'b0;
      end else if (en) begin
         outv_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = outv_ff;
   assign rsp_mask_value = out_ff;

endmodule

FILE: src/twm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the transition wipe mask generator, bound to the top.
// Depends on twm_pkg and transition_wipe_mask_gen.
module twm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [twm_pkg::MASK_W-1:0]     rsp_mask_value,
   input logic                           csr_we
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mask_value))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_settle_first: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("req accepted right after csr write");

   a_settle_second: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> ##2 !req_ready)
      else $error("req accepted before config settled");

endmodule

bind transition_wipe_mask_gen twm_checker u_twm_checker (.*);

FILE: tb/sv/transition_wipe_mask_gen_checker.sv
`timescale 1ns / 1ps
// Watches the req, rsp and csr ports of transition_wipe_mask_gen, predicts each mask byte
// from its own copy of the registers and compares results in order. Depends on twm_pkg.
module transition_wipe_mask_gen_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [11:0]                    req_pixel_x,
   input  logic [11:0]                    req_pixel_y,
   input  logic [twm_pkg::GRAY_W-1:0]     req_mask_gray,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [twm_pkg::MASK_W-1:0]     rsp_mask_value,
   input  logic                           csr_we,
   input  logic [twm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [twm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count
);

   localparam longint unsigned BLIND_PERIOD  = 16;
   localparam longint unsigned CURTAIN_BLOCK = 24;

   logic [twm_pkg::MODE_W-1:0] cur_mode;
   logic [twm_pkg::DIR_W-1:0]  cur_dir;
   logic [twm_pkg::DUR_W-1:0]  cur_duration;
   logic [twm_pkg::DUR_W-1:0]  cur_elapsed;
   logic [twm_pkg::EXT_W-1:0]  cur_width;
   logic [twm_pkg::EXT_W-1:0]  cur_height;
   logic [twm_pkg::MASK_W-1:0] expected_masks[$];

   function automatic logic [twm_pkg::MASK_W-1:0] blinds_mask(longint unsigned c, bit far,
                                                              longint unsigned d,
                                                              longint unsigned e);
      longint unsigned step, n, m;
      step = d / BLIND_PERIOD;
      if (step == 0) step = 1;
      n = e / step;
      m = c % BLIND_PERIOD;
      if (far) m = BLIND_PERIOD - 1 - m;
      return (m < n) ? twm_pkg::MASK_HIDE : twm_pkg::MASK_SHOW;
   endfunction

   function automatic logic [twm_pkg::MASK_W-1:0] curtain_mask(longint unsigned p,
                                                               longint unsigned x,
                                                               bit far, longint unsigned d,
                                                               longint unsigned e);
      longint unsigned blocks, tt, id, o, den, delay, r, n;
      blocks = (x + CURTAIN_BLOCK - 1) / CURTAIN_BLOCK;
      den = 2 * blocks;
      tt = (d < den) ? den : d;
      id = p / CURTAIN_BLOCK;
      o = p % CURTAIN_BLOCK;
      delay = (tt * id + den - 1) / den;
      if (e <= delay) return twm_pkg::MASK_SHOW;
      r = e - delay;
      if (2 * r > tt) return twm_pkg::MASK_HIDE;
      n = (2 * CURTAIN_BLOCK * r + tt - 1) / tt;
      if (far) return (o + n >= CURTAIN_BLOCK) ? twm_pkg::MASK_HIDE : twm_pkg::MASK_SHOW;
      return (o < n) ? twm_pkg::MASK_HIDE : twm_pkg::MASK_SHOW;
   endfunction

   function automatic logic [twm_pkg::MASK_W-1:0] gray_mask(longint unsigned g,
                                                            bit soft_mode,
                                                            longint unsigned d,
                                                            longint unsigned e);
      longint unsigned t;
      t = (d * g) / 255;
      if (e > t) return twm_pkg::MASK_HIDE;
      if (!soft_mode || t == 0) return twm_pkg::MASK_SHOW;
      return twm_pkg::MASK_W'(((t - e) * 255) / t);
   endfunction

   function automatic logic [twm_pkg::MASK_W-1:0] predict_mask(longint unsigned px,
                                                               longint unsigned py,
                                                               longint unsigned g);
      longint unsigned d, e, c, x, p;
      bit vert, far;
      logic [twm_pkg::MASK_W-1:0] v;
      d = (cur_duration == 0) ? 1 : cur_duration;
      e = (cur_elapsed > d) ? d : cur_elapsed;
      vert = (cur_dir == twm_pkg::DIR_TOP) || (cur_dir == twm_pkg::DIR_BOTTOM);
      far = (cur_dir == twm_pkg::DIR_RIGHT) || (cur_dir == twm_pkg::DIR_BOTTOM);
      c = vert ? py : px;
      x = vert ? cur_height : cur_width;
      v = twm_pkg::MASK_SHOW;
      case (cur_mode)
         twm_pkg::MODE_BLINDS: v = blinds_mask(c, far, d, e);
         twm_pkg::MODE_CURTAIN, twm_pkg::MODE_ROLL: begin
            if (c < x) begin
               p = far ? (x - 1 - c) : c;
               if (cur_mode == twm_pkg::MODE_CURTAIN) v = curtain_mask(p, x, far, d, e);
               else v = (p <= (e * x) / d) ? twm_pkg::MASK_HIDE : twm_pkg::MASK_SHOW;
            end
         end
         twm_pkg::MODE_MASK_HARD: v = gray_mask(g, 1'b0, d, e);
         twm_pkg::MODE_MASK_SOFT: v = gray_mask(g, 1'b1, d, e);
         default: v = twm_pkg::MASK_SHOW;
      endcase
      return v;
   endfunction

   always_ff @(posedge clock) begin
      logic [twm_pkg::MASK_W-1:0] want;
      if (reset) begin
         cur_mode <= twm_pkg::MODE_BLINDS;
         cur_dir <= twm_pkg::DIR_LEFT;
         cur_duration <= 16'd1000;
         cur_elapsed <= 16'd0;
         cur_width <= 13'd640;
         cur_height <= 13'd480;
         expected_masks.delete();
         fail_count <= 0;
         checked_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               twm_pkg::REG_MODE:      cur_mode <= csr_wdata[twm_pkg::MODE_W-1:0];
               twm_pkg::REG_DIRECTION: cur_dir <= csr_wdata[twm_pkg::DIR_W-1:0];
               twm_pkg::REG_DURATION:  cur_duration <= csr_wdata;
               twm_pkg::REG_ELAPSED:   cur_elapsed <= csr_wdata;
               twm_pkg::REG_WIDTH:     cur_width <= csr_wdata[twm_pkg::EXT_W-1:0];
               twm_pkg::REG_HEIGHT:    cur_height <= csr_wdata[twm_pkg::EXT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_masks.push_back(predict_mask(req_pixel_x, req_pixel_y, req_mask_gray));
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (expected_masks.size() == 0) begin
               $display("%0t: unexpected word, actual mask_value %0d", $time, rsp_mask_value);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_masks.pop_front();
               if (want !== rsp_mask_value) begin
                  $display("%0t: mask_value expected %0d actual %0d",
                           $time, want, rsp_mask_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_masks.size();
      end
   end

endmodule

FILE: tb/sv/transition_wipe_mask_gen_test.sv
`timescale 1ns / 1ps
// Top of the transition_wipe_mask_gen testbench: clock, reset, register phases and pixel
// stimulus with random idling. Depends on twm_pkg, the DUT, transition_wipe_mask_gen_checker.
module transition_wipe_mask_gen_test;

   localparam int PHASES = 30;
   localparam int WORDS_PER_PHASE = 55;
   localparam int CYCLE_LIMIT = 300000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [11:0]                    req_pixel_x;
   logic [11:0]                    req_pixel_y;
   logic [twm_pkg::GRAY_W-1:0]     req_mask_gray;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [twm_pkg::MASK_W-1:0]     rsp_mask_value;
   logic                           csr_we;
   logic [twm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [twm_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                             fail_count;
   int                             pending_count;
   int                             checked_count;
   int                             cycle_count;
   bit                             long_hold;
   bit                             rsp_no_idle;
   bit                             req_no_idle;

   transition_wipe_mask_gen u_dut (.*);

   transition_wipe_mask_gen_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      req_mask_gray = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = twm_pkg::REG_MODE;
      csr_wdata = '0;
      long_hold = 1'b0;
      rsp_no_idle = 1'b0;
      req_no_idle = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= reset ? 0 : cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // drain results with random stalls and one long hold-off
   initial begin
      bit taken;
      int stall;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = rsp_no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            taken = rsp_valid && rsp_ready;
            @(posedge clock);
         end while (!taken);
      end
   end

   task automatic send_word(input logic [11:0] px, input logic [11:0] py,
                            input logic [7:0] g);
      bit taken;
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_mask_gray <= g;
      do begin
         @(negedge clock);
         taken = req_valid && req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_reg(input twm_pkg::csr_index_type idx,
                            input logic [twm_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_duration();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'($urandom_range(15, 17));
         3: return 16'd65535;
         4: return 16'($urandom_range(2, 100));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [12:0] pick_extent();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'($urandom_range(23, 25));
         3: return 13'd4096;
         4: return 13'd8191;
         5: return 13'($urandom_range(4097, 8190));
         6: return 13'($urandom_range(2, 100));
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [11:0] pick_coord(input logic [12:0] extent);
      if (extent != 0 && $urandom_range(0, 3) != 0)
         return 12'($urandom_range(0, (extent > 4096 ? 4096 : extent) - 1));
      if ($urandom_range(0, 1)) return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      return 12'($urandom());
   endfunction

   initial begin
      logic [2:0]  mode;
      logic [1:0]  dir;
      logic [15:0] duration;
      logic [15:0] elapsed;
      logic [12:0] width;
      logic [12:0] height;
      int          n_words;
      @(negedge reset);
      @(posedge clock);
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            req_valid <= 1'b0;
            while (pending_count != 0) @(posedge clock);
            repeat (40) @(posedge clock);
         end
         mode = 3'(ph % 8);
         dir = 2'((ph / 8 + ph) % 4);
         duration = (ph == 0) ? 16'd65535 : (ph == 1) ? 16'd0 : pick_duration();
         case ($urandom_range(0, 5))
            0: elapsed = 16'd0;
            1: elapsed = 16'd65535;
            2: elapsed = duration;
            default: elapsed = 16'($urandom_range(0, duration == 0 ? 1 : duration));
         endcase
         width = (ph == 0) ? 13'd8191 : (ph == 1) ? 13'd0 : pick_extent();
         height = (ph == 0) ? 13'd0 : (ph == 1) ? 13'd4096 : pick_extent();
         write_reg(twm_pkg::REG_MODE, 16'(mode));
         write_reg(twm_pkg::REG_DIRECTION, 16'(dir));
         write_reg(twm_pkg::REG_DURATION, duration);
         write_reg(twm_pkg::REG_ELAPSED, elapsed);
         write_reg(twm_pkg::REG_WIDTH, 16'(width));
         write_reg(twm_pkg::REG_HEIGHT, 16'(height));
         csr_we <= 1'b0;
         rsp_no_idle = (ph % 7 == 5);
         req_no_idle = (ph % 5 == 4);
         if (ph == 3) long_hold = 1'b1;
         // edge pixels first
         send_word(12'd0, 12'd0, 8'd0);
         send_word(12'd4095, 12'd4095, 8'd255);
         send_word(12'(width - 1), 12'(height - 1), 8'd1);
         send_word(12'(width), 12'(height), 8'd254);
         n_words = WORDS_PER_PHASE - 4;
         for (int i = 0; i < n_words; i++)
            send_word(pick_coord(width), pick_coord(height), 8'($urandom()));
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d register phases over all effect modes and directions,",
               PHASES);
      $display("%0d mask words compared, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
src/twm_pkg.sv
src/twm_div.sv
src/twm_front.sv
src/transition_wipe_mask_gen.sv
src/twm_checker.sv
tb/sv/transition_wipe_mask_gen_checker.sv
tb/sv/transition_wipe_mask_gen_test.sv
